>>> hdl/tlblru_pkg.sv
// Shared types and constants for the LRU translation buffer.
// Used by tlblru_ctrl, tlblru_dp and tlb_lru_replacement; no dependencies.
package tlblru_pkg;

   localparam int PAGE_W  = 32;
   localparam int FRAME_W = 32;
   localparam int TIME_W  = 31;
   localparam int CAP_W   = 5;

   localparam int REQ_TDATA_W = 96;  // vpn, frame_in, access_time, pad
   localparam int RSP_TDATA_W = 64;  // frame_out, evicted_vpn
   localparam int RSP_TUSER_W = 2;   // hit, evicted

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Register index, taken from paddr[2]
   localparam logic REG_TLB_CAPACITY = 1'b0;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_READ,
      ST_FILL,
      ST_SCAN,
      ST_DRAIN,
      ST_EVICT,
      ST_RESP
   } tlblru_state_type;

   typedef struct packed {
      logic load;        // capture the request
      logic match;       // register compare result
      logic frame_rd;    // read frame of matched slot; refresh time on insert
      logic scan_start;  // clear the victim search
      logic scan_step;   // read one slot's time and page
      logic fill;        // write an empty slot
      logic evict;       // overwrite the victim slot
      logic resp_load;   // load the output register
   } tlblru_cmd_type;

   typedef struct packed {
      logic action;
      logic hit;
      logic room;        // fewer slots used than the capacity
      logic scan_last;   // last slot read is being issued
      logic out_busy;    // output register holds an untaken result
   } tlblru_status_type;

endpackage

>>> hdl/tlb_lru_replacement.sv
// Top level of the fully associative translation buffer with LRU replacement.
// Holds the capacity register and its APB port; depends on tlblru_pkg,
// tlblru_ctrl and tlblru_dp.
//
//   channel   ports      direction   carries
//   request   req_*      in          action, vpn, frame_in, access_time
//   result    rsp_*      out         hit, frame_out, evicted, evicted_vpn
//   config    csr_*      in/out      tlb_capacity at byte address 0
//
// Lookup, hit or refresh: accept, compare, frame read, result load. A fill
// of an empty slot adds a fill step. Eviction adds the one-slot-per-cycle
// oldest-entry search over the time memory, a drain step and the victim
// write. One request is in flight; the next is accepted while a result
// still waits in the output register. Reset empties the buffer at once.
module tlb_lru_replacement #(
   parameter int TLB_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] vpn, [63:32] frame_in, [94:64] access_time, [95] zero
   input  logic [tlblru_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] action
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] frame_out, [63:32] evicted_vpn
   output logic [tlblru_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] hit, [1] evicted
   output logic [tlblru_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tlblru_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tlblru_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tlblru_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import tlblru_pkg::*;

   localparam int CW = $clog2(TLB_DEPTH + 1);

   logic [CAP_W-1:0] cap_raw_ff;
   logic [CW-1:0]    cap_eff;
   logic [CW-1:0]    cfg_cap;
   logic             cfg_wr;

   tlblru_cmd_type    cmd;
   tlblru_status_type status;

   logic              rsp_hit, rsp_evicted;
   logic [FRAME_W-1:0] rsp_frame;
   logic [PAGE_W-1:0]  rsp_evicted_vpn;

   // zero reads as one, anything above the depth as the depth
   function automatic logic [CW-1:0] clamp_cap(input logic [CAP_W-1:0] raw);
      logic [CW-1:0] c;
      if (raw == '0) begin
         c = CW'(1);
      end else if (32'(raw) > 32'(TLB_DEPTH)) begin
         c = CW'(TLB_DEPTH);
      end else begin
         c = CW'(raw);
      end
      return c;
   endfunction

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_TLB_CAPACITY);
   assign cfg_cap    = clamp_cap(csr_pwdata[CAP_W-1:0]);
   assign cap_eff    = clamp_cap(cap_raw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_raw_ff <= CAP_RESET;
      end else if (cfg_wr) begin
         cap_raw_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_TLB_CAPACITY: csr_prdata = CSR_DATA_W'(cap_raw_ff);
         default:          csr_prdata = '0;
      endcase
   end

   tlblru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tlblru_dp #(
      .TLB_DEPTH (TLB_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cap_eff         (cap_eff),
      .cfg_wr          (cfg_wr),
      .cfg_cap         (cfg_cap),
      .req_action      (req_tuser),
      .req_vpn         (req_tdata[31:0]),
      .req_frame       (req_tdata[63:32]),
      .req_time        (req_tdata[94:64]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_hit         (rsp_hit),
      .rsp_frame       (rsp_frame),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_vpn (rsp_evicted_vpn)
   );

   assign rsp_tdata = {rsp_evicted_vpn, rsp_frame};
   assign rsp_tuser = {rsp_evicted, rsp_hit};

`ifndef SYNTH
   // one request at a time: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("result loaded over an untaken result");

   // eviction only follows a miss
   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> (!status.hit && !status.room))
      else $error("eviction on a hit or with free slots");
`endif

endmodule

>>> hdl/tlblru_dp.sv
// Datapath of the LRU translation buffer: page tags with parallel compare,
// frame/time/page memories, sequential oldest-entry search, output register.
// Depends on tlblru_pkg.
module tlblru_dp #(
   parameter int TLB_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tlblru_pkg::tlblru_cmd_type             cmd,
   output tlblru_pkg::tlblru_status_type          status,
   input  logic [$clog2(TLB_DEPTH+1)-1:0]         cap_eff,
   input  logic                                   cfg_wr,
   input  logic [$clog2(TLB_DEPTH+1)-1:0]         cfg_cap,
   input  logic                                   req_action,
   input  logic [tlblru_pkg::PAGE_W-1:0]          req_vpn,
   input  logic [tlblru_pkg::FRAME_W-1:0]         req_frame,
   input  logic [tlblru_pkg::TIME_W-1:0]          req_time,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic [tlblru_pkg::FRAME_W-1:0]         rsp_frame,
   output logic                                   rsp_evicted,
   output logic [tlblru_pkg::PAGE_W-1:0]          rsp_evicted_vpn
);
   import tlblru_pkg::*;

   localparam int IW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
   localparam int CW = $clog2(TLB_DEPTH + 1);

   // request
   logic               action_ff;
   logic [PAGE_W-1:0]  vpn_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [TIME_W-1:0]  stamp_ff;

   // valid slots always form the prefix [0, used)
   logic [CW-1:0]      used_ff, used_in;

   logic [PAGE_W-1:0]  page_ff [TLB_DEPTH];
   logic [FRAME_W-1:0] frame_mem [TLB_DEPTH];
   logic [TIME_W-1:0]  time_mem [TLB_DEPTH];
   logic [PAGE_W-1:0]  page_mem [TLB_DEPTH];

   logic [TLB_DEPTH-1:0] match_vec;
   logic [IW-1:0]        match_enc;
   logic                 hit_ff;
   logic [IW-1:0]        match_idx_ff;
   logic [FRAME_W-1:0]   frame_rd_ff;

   // victim search
   logic [CW-1:0]      scan_cnt_ff;
   logic               rd_vld_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic [TIME_W-1:0]  time_rd_ff;
   logic [PAGE_W-1:0]  page_rd_ff;
   logic [TIME_W-1:0]  min_time_ff;
   logic [IW-1:0]      victim_ff;
   logic [PAGE_W-1:0]  victim_page_ff;
   logic               evict_ff;

   logic               wr_en;
   logic [IW-1:0]      wr_idx;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic               rsp_evict_ff;
   logic [PAGE_W-1:0]  rsp_evpn_ff;

   always_comb begin
      match_enc = '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
         match_vec[i] = (CW'(i) < used_ff) && (page_ff[i] == vpn_ff);
      end
      // lowest matching slot wins
      for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_enc = IW'(i);
         end
      end
   end

   assign wr_en  = cmd.fill || cmd.evict;
   assign wr_idx = cmd.fill ? used_ff[IW-1:0] : victim_ff;

   always_comb begin
      used_in = used_ff;
      if (cfg_wr) begin
         used_in = (used_ff > cfg_cap) ? cfg_cap : used_ff;
      end else if (cmd.fill) begin
         used_in = used_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         vpn_ff    <= req_vpn;
         frame_ff  <= req_frame;
         stamp_ff  <= req_time;
      end
      if (cmd.match) begin
         hit_ff       <= |match_vec;
         match_idx_ff <= match_enc;
      end
   end

   // tag flops, compared in parallel
   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_ff[wr_idx] <= vpn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_idx] <= frame_ff;
      end
      if (cmd.frame_rd) begin
         frame_rd_ff <= frame_mem[match_idx_ff];
      end
   end

   // refresh of a present page shares the write port with fill and evict
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_idx] <= stamp_ff;
      end else if (cmd.frame_rd && hit_ff && action_ff == ACT_INSERT) begin
         time_mem[match_idx_ff] <= stamp_ff;
      end
      if (cmd.scan_step) begin
         time_rd_ff <= time_mem[scan_cnt_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_idx] <= vpn_ff;
      end
      if (cmd.scan_step) begin
         page_rd_ff <= page_mem[scan_cnt_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_cnt_ff <= scan_cnt_ff + CW'(1);
      end
      if (cmd.scan_step) begin
         rd_idx_ff <= scan_cnt_ff[IW-1:0];
      end
      // strict compare keeps the lowest slot among equal times
      if (rd_vld_ff && (rd_idx_ff == '0 || time_rd_ff < min_time_ff)) begin
         min_time_ff    <= time_rd_ff;
         victim_ff      <= rd_idx_ff;
         victim_page_ff <= page_rd_ff;
      end
      if (cmd.load) begin
         evict_ff <= 1'b0;
      end else if (cmd.evict) begin
         evict_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_hit_ff   <= hit_ff;
         rsp_frame_ff <= hit_ff ? frame_rd_ff : '0;
         rsp_evict_ff <= evict_ff;
         rsp_evpn_ff  <= evict_ff ? victim_page_ff : '0;
      end
   end

   assign status.action    = action_ff;
   assign status.hit       = hit_ff;
   assign status.room      = used_ff < cap_eff;
   assign status.scan_last = scan_cnt_ff == (cap_eff - CW'(1));
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame       = rsp_frame_ff;
   assign rsp_evicted     = rsp_evict_ff;
   assign rsp_evicted_vpn = rsp_evpn_ff;

endmodule

>>> hdl/tlblru_ctrl.sv
// Sequencer of the LRU translation buffer: steps one request through
// compare, frame read, fill or victim search, and result load.
// Depends on tlblru_pkg.
module tlblru_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tlblru_pkg::tlblru_status_type status,
   output tlblru_pkg::tlblru_cmd_type    cmd
);
   import tlblru_pkg::*;

   tlblru_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            cmd.frame_rd   = 1'b1;
            cmd.scan_start = 1'b1;
            if (status.hit || status.action == ACT_LOOKUP) begin
               state_in = ST_RESP;
            end else if (status.room) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last slot's data is compared here
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (!status.out_busy) begin
               cmd.resp_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
